[sv/drive_command_line_parser_macros.svh]
// ----------------------------------------------------------------------------
// Drive command line parser assertion macros
// Shared property forms for the checker, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_LINE_PARSER_MACROS_SVH
`define DRIVE_COMMAND_LINE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dclp_pkg.sv]
// ----------------------------------------------------------------------------
// Drive command line parser package
// Field widths, character codes, command codes and number scaling constants.
// ----------------------------------------------------------------------------
package dclp_pkg;

  localparam int FRACTION_DIGITS = 4;
  localparam int INTEGER_DIGITS  = 5;

  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 4;
  localparam int SPEED_W    = 16;
  localparam int COORD_W    = 31;
  localparam int FIELD_W    = 2;
  localparam int FRAC_CNT_W = 3;
  localparam int DIGIT_W    = 4;

  localparam longint MAG_CAP = 64'd999999999;

  // Largest magnitude in units of 1e-4: ten to the power of the digit count,
  // less one, but never beyond nine nines.
  function automatic longint mag_limit_f();
    longint v;
    v = 1;
    for (int i = 0; i < INTEGER_DIGITS + 4; i++) begin
      if (v <= MAG_CAP) begin
        v = v * 10;
      end
    end
    v = v - 1;
    return (v > MAG_CAP) ? MAG_CAP : v;
  endfunction

  localparam longint MAG_LIMIT = mag_limit_f();
  localparam int     MAG_W     = $clog2(MAG_LIMIT + 1);
  localparam int     WIDE_W    = MAG_W + 4;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_EIGHT = 8'h38;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  localparam logic [CMD_W-1:0] CMD_SPEED = 4'd7;
  localparam logic [CMD_W-1:0] CMD_POINT = 4'd8;
  localparam logic [CMD_W-1:0] CMD_NONE  = 4'd9;

  localparam logic [FIELD_W-1:0] FIELD_CMD   = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_FIRST = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_Y     = 2'd2;
  localparam logic [FIELD_W-1:0] FIELD_EXTRA = 2'd3;

  localparam logic [WIDE_W-1:0] INT_DIGIT_SCALE = WIDE_W'(10000);

  typedef struct packed {
    logic                  negative;
    logic                  fraction;
    logic [FRAC_CNT_W-1:0] count;
  } num_flags_t;

  // Weight of a fraction digit by its position, the first being tenths.
  function automatic logic [WIDE_W-1:0] frac_weight(input logic [FRAC_CNT_W-1:0] pos);
    logic [WIDE_W-1:0] w;
    unique case (pos)
      3'd1:    w = WIDE_W'(1000);
      3'd2:    w = WIDE_W'(100);
      3'd3:    w = WIDE_W'(10);
      3'd4:    w = WIDE_W'(1);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[sv/dclp_if.sv]
// ----------------------------------------------------------------------------
// Drive command line parser channels
// Valid/ready channels for the incoming bytes and the outgoing results.
// ----------------------------------------------------------------------------
interface dclp_byte_if
  import dclp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

interface dclp_result_if
  import dclp_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic [SPEED_W-1:0]        speed_tenths;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;

  modport source (output valid, output command, output speed_tenths,
                  output target_x, output target_y, input ready);
  modport sink   (input valid, input command, input speed_tenths,
                  input target_x, input target_y, output ready);
endinterface

[sv/dclp_num_acc.sv]
// ----------------------------------------------------------------------------
// Drive command line parser number accumulator
// Folds one byte into a decimal magnitude held in units of 1e-4.
// ----------------------------------------------------------------------------
module dclp_num_acc
  import dclp_pkg::*;
(
  input  logic [MAG_W-1:0]  acc,
  input  logic [BYTE_W-1:0] ch,
  input  num_flags_t        flags,
  output logic [MAG_W-1:0]  acc_next,
  output num_flags_t        flags_next
);

  logic                  is_digit;
  logic [DIGIT_W-1:0]    digit;
  logic [FRAC_CNT_W-1:0] count_inc;
  logic [WIDE_W-1:0]     wide;
  logic                  take;

  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign digit     = DIGIT_W'(ch - CH_ZERO);
  assign count_inc = flags.count + 1'b1;

  always_comb begin
    flags_next = flags;
    wide       = WIDE_W'(acc);
    take       = 1'b0;
    priority if (ch == CH_MINUS) begin
      flags_next.negative = 1'b1;
    end else if (ch == CH_DOT) begin
      flags_next.fraction = 1'b1;
    end else if (is_digit) begin
      if (!flags.fraction) begin
        wide = WIDE_W'(acc) * WIDE_W'(10) + WIDE_W'(digit) * INT_DIGIT_SCALE;
        take = 1'b1;
      end else if (32'(flags.count) < FRACTION_DIGITS) begin
        flags_next.count = count_inc;
        // Digits beyond the fourth fall below one ten-thousandth and add nothing.
        wide = WIDE_W'(acc) + WIDE_W'(digit) * frac_weight(count_inc);
        take = 1'b1;
      end
    end else begin
      // Any other byte is skipped and leaves the number as it is.
      take = 1'b0;
    end
    if (!take) begin
      acc_next = acc;
    end else if (wide > WIDE_W'(MAG_LIMIT)) begin
      acc_next = MAG_W'(MAG_LIMIT);
    end else begin
      acc_next = wide[MAG_W-1:0];
    end
  end

endmodule

[sv/drive_command_line_parser.sv]
// ----------------------------------------------------------------------------
// Drive command line parser
// Parses comma-separated drive commands byte by byte into one result a line.
// ----------------------------------------------------------------------------
// Bytes of a command line enter on byte_ch (text_byte, with line_end set on
// the final byte). One result per line leaves on result_ch: the command code,
// the speed in tenths for command 7, and the target point for command 8.
// A byte is taken into an input register, and in the following cycle the line
// state is updated from it by single-pass logic; the final byte of a line
// loads the result register instead and returns the line state to its start.
// Throughput is one byte per cycle while no final byte waits for the result
// register. A result is shown once its final byte has passed from the input
// register into the result register, which it enters when that is free.
// While the receiver stalls, bytes that do not end a line keep flowing; a
// final byte waits in the input register until the result register is free.
// Reset is synchronous: it empties both registers and starts a new line with
// command code nine.
// ----------------------------------------------------------------------------
module drive_command_line_parser
  import dclp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  dclp_byte_if.sink        byte_ch,
  dclp_result_if.source    result_ch
);

  logic              a_valid;
  logic [BYTE_W-1:0] a_byte;
  logic              a_last;
  logic              a_advance;

  logic [FIELD_W-1:0]        field_index, field_index_next;
  logic                      line_start, line_start_next;
  logic [CMD_W-1:0]          command_code, command_code_next;
  num_flags_t                flags, flags_next;
  logic [SPEED_W-1:0]        speed_acc, speed_acc_next;
  logic signed [COORD_W-1:0] x_acc, x_acc_next;
  logic signed [COORD_W-1:0] y_acc, y_acc_next;

  logic [MAG_W-1:0]          num_acc, num_acc_next;
  num_flags_t                num_flags_next;
  logic                      is_digit;
  logic [SPEED_W+3:0]        speed_wide;

  logic signed [COORD_W-1:0] x_closed, y_closed;
  logic [CMD_W-1:0]          out_cmd;
  logic [SPEED_W-1:0]        out_speed;
  logic signed [COORD_W-1:0] out_x, out_y;

  logic                      res_valid;
  logic [CMD_W-1:0]          res_cmd;
  logic [SPEED_W-1:0]        res_speed;
  logic signed [COORD_W-1:0] res_x, res_y;

  // A final byte may only move on when the result register can take it.
  assign a_advance     = a_valid && !(a_last && res_valid && !result_ch.ready);
  assign byte_ch.ready = !a_valid || a_advance;

  assign num_acc  = (field_index == FIELD_Y) ? y_acc[MAG_W-1:0] : x_acc[MAG_W-1:0];
  assign is_digit = (a_byte >= CH_ZERO) && (a_byte <= CH_NINE);

  dclp_num_acc u_num_acc (
    .acc        (num_acc),
    .ch         (a_byte),
    .flags      (flags),
    .acc_next   (num_acc_next),
    .flags_next (num_flags_next)
  );

  always_comb begin
    field_index_next  = field_index;
    line_start_next   = line_start;
    command_code_next = command_code;
    flags_next        = flags;
    speed_acc_next    = speed_acc;
    x_acc_next        = x_acc;
    y_acc_next        = y_acc;
    speed_wide        = (SPEED_W + 4)'(speed_acc) * (SPEED_W + 4)'(10)
                      + (SPEED_W + 4)'(DIGIT_W'(a_byte - CH_ZERO));
    priority if (line_start) begin
      line_start_next = 1'b0;
      if ((a_byte >= CH_ZERO) && (a_byte <= CH_EIGHT)) begin
        command_code_next = CMD_W'(a_byte - CH_ZERO);
      end else begin
        command_code_next = CMD_NONE;
      end
    end else if (a_byte == CH_COMMA) begin
      if (field_index == FIELD_FIRST && flags.negative) begin
        x_acc_next = -x_acc;
      end
      if (field_index == FIELD_Y && flags.negative) begin
        y_acc_next = -y_acc;
      end
      flags_next = '0;
      if (field_index != FIELD_EXTRA) begin
        field_index_next = field_index + 1'b1;
      end
    end else if (field_index == FIELD_FIRST) begin
      if (is_digit) begin
        speed_acc_next = (speed_wide > (SPEED_W + 4)'(SPEED_MAX)) ?
                         SPEED_MAX : speed_wide[SPEED_W-1:0];
      end
      x_acc_next = COORD_W'(num_acc_next);
      flags_next = num_flags_next;
    end else if (field_index == FIELD_Y) begin
      y_acc_next = COORD_W'(num_acc_next);
      flags_next = num_flags_next;
    end else begin
      // Later bytes of the command field and bytes of extra fields are ignored.
      flags_next = flags;
    end
  end

  // The end of the line also closes the open field.
  always_comb begin
    x_closed = (field_index_next == FIELD_FIRST && flags_next.negative) ?
               -x_acc_next : x_acc_next;
    y_closed = (field_index_next == FIELD_Y && flags_next.negative) ?
               -y_acc_next : y_acc_next;
    out_cmd   = command_code_next;
    out_speed = (command_code_next == CMD_SPEED) ? speed_acc_next : '0;
    out_x     = '0;
    out_y     = '0;
    if (command_code_next == CMD_POINT) begin
      out_x = x_closed;
      out_y = (!x_closed[COORD_W-1] && (x_closed != '0)) ? -y_closed : y_closed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      res_valid    <= 1'b0;
      field_index  <= FIELD_CMD;
      line_start   <= 1'b1;
      command_code <= CMD_NONE;
      flags        <= '0;
      speed_acc    <= '0;
      x_acc        <= '0;
      y_acc        <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        a_valid <= 1'b1;
      end else if (a_advance) begin
        a_valid <= 1'b0;
      end
      if (a_advance && a_last) begin
        res_valid <= 1'b1;
      end else if (result_ch.ready) begin
        res_valid <= 1'b0;
      end
      if (a_advance) begin
        if (a_last) begin
          field_index  <= FIELD_CMD;
          line_start   <= 1'b1;
          command_code <= CMD_NONE;
          flags        <= '0;
          speed_acc    <= '0;
          x_acc        <= '0;
          y_acc        <= '0;
        end else begin
          field_index  <= field_index_next;
          line_start   <= line_start_next;
          command_code <= command_code_next;
          flags        <= flags_next;
          speed_acc    <= speed_acc_next;
          x_acc        <= x_acc_next;
          y_acc        <= y_acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.valid && byte_ch.ready) begin
      a_byte <= byte_ch.text_byte;
      a_last <= byte_ch.line_end;
    end
    if (a_advance && a_last) begin
      res_cmd   <= out_cmd;
      res_speed <= out_speed;
      res_x     <= out_x;
      res_y     <= out_y;
    end
  end

  assign result_ch.valid        = res_valid;
  assign result_ch.command      = res_cmd;
  assign result_ch.speed_tenths = res_speed;
  assign result_ch.target_x     = res_x;
  assign result_ch.target_y     = res_y;

endmodule

[sv/dclp_checker.sv]
// ----------------------------------------------------------------------------
// Drive command line parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "drive_command_line_parser_macros.svh"

module dclp_checker
  import dclp_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [CMD_W-1:0]          command,
  input logic [SPEED_W-1:0]        speed_tenths,
  input logic signed [COORD_W-1:0] target_x,
  input logic signed [COORD_W-1:0] target_y
);

  `DCLP_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(command) && $stable(speed_tenths) && $stable(target_x) && $stable(target_y), "stalled result changed")
  `DCLP_ASSERT_SAME(a_command_range, out_valid, command <= CMD_NONE, "command code out of range")
  `DCLP_ASSERT_SAME(a_speed_only_cmd7, out_valid && command != CMD_SPEED, speed_tenths == '0, "speed given for a command other than set speed")
  `DCLP_ASSERT_SAME(a_point_only_cmd8, out_valid && command != CMD_POINT, target_x == '0 && target_y == '0, "target given for a command other than go to point")

endmodule

bind drive_command_line_parser dclp_checker u_dclp_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_ch.valid),
  .out_ready    (result_ch.ready),
  .command      (result_ch.command),
  .speed_tenths (result_ch.speed_tenths),
  .target_x     (result_ch.target_x),
  .target_y     (result_ch.target_y)
);

[dv/tb_drive_command_line_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command line parser testbench
// Sends directed and random command lines byte by byte through the valid/ready
// channels under four handshake phases. A scoreboard class parses each accepted
// item on its own and checks every result field against its expectation.
// ----------------------------------------------------------------------------
module tb_drive_command_line_parser;
  import dclp_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_BYTES  = 215;
  localparam int GAP_PCT[4]   = '{0, 87, 0, 26};
  localparam int STALL_PCT[4] = '{0, 0, 87, 26};

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic [SPEED_W-1:0]        speed_tenths;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
  } line_result_t;

  // Parses the line as the block should and holds the results still owed.
  class line_result_board;
    logic [FIELD_W-1:0] field_idx;
    bit                 first_byte;
    logic [CMD_W-1:0]   cmd_code;
    bit                 minus_seen;
    bit                 dot_seen;
    int unsigned        frac_count;
    int unsigned        speed_acc;
    longint             x_mag;
    longint             y_mag;

    line_result_t awaited[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  point_lines;
    int unsigned  speed_lines;

    function new();
      mismatches      = 0;
      results_checked = 0;
      point_lines     = 0;
      speed_lines     = 0;
      restart_line();
    endfunction

    function void restart_line();
      field_idx  = FIELD_CMD;
      first_byte = 1'b1;
      cmd_code   = CMD_NONE;
      minus_seen = 1'b0;
      dot_seen   = 1'b0;
      frac_count = 0;
      speed_acc  = 0;
      x_mag      = 0;
      y_mag      = 0;
    endfunction

    function void close_number();
      if (field_idx == FIELD_FIRST && minus_seen) x_mag = -x_mag;
      if (field_idx == FIELD_Y && minus_seen) y_mag = -y_mag;
      minus_seen = 1'b0;
      dot_seen   = 1'b0;
      frac_count = 0;
    endfunction

    // Magnitudes are held in units of 1e-4.
    function longint number_byte(longint acc, logic [BYTE_W-1:0] c);
      longint v;
      longint w;
      v = acc;
      if (c == CH_MINUS) begin
        minus_seen = 1'b1;
        return acc;
      end
      if (c == CH_DOT) begin
        dot_seen = 1'b1;
        return acc;
      end
      if (c < CH_ZERO || c > CH_NINE) return acc;
      if (!dot_seen) begin
        v = v * 10 + longint'(c - CH_ZERO) * 10000;
      end else begin
        if (frac_count >= FRACTION_DIGITS) return acc;
        frac_count++;
        if (frac_count <= 4) begin
          w = 1;
          repeat (4 - frac_count) w = w * 10;
          v = v + longint'(c - CH_ZERO) * w;
        end
      end
      if (v > MAG_LIMIT) v = MAG_LIMIT;
      return v;
    endfunction

    function void parse_byte(logic [BYTE_W-1:0] c, logic last);
      line_result_t want;
      longint x;
      longint y;
      if (first_byte) begin
        cmd_code   = (c >= CH_ZERO && c <= CH_EIGHT) ? CMD_W'(c - CH_ZERO) : CMD_NONE;
        first_byte = 1'b0;
      end else if (c == CH_COMMA) begin
        close_number();
        if (field_idx != FIELD_EXTRA) field_idx++;
      end else if (field_idx == FIELD_FIRST) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          speed_acc = speed_acc * 10 + (c - CH_ZERO);
          if (speed_acc > SPEED_MAX) speed_acc = SPEED_MAX;
        end
        x_mag = number_byte(x_mag, c);
      end else if (field_idx == FIELD_Y) begin
        y_mag = number_byte(y_mag, c);
      end
      if (!last) return;

      close_number();
      x = 0;
      y = 0;
      if (cmd_code == CMD_POINT) begin
        x = x_mag;
        y = (x_mag > 0) ? -y_mag : y_mag;
        point_lines++;
      end
      if (cmd_code == CMD_SPEED) speed_lines++;
      want.command      = cmd_code;
      want.speed_tenths = (cmd_code == CMD_SPEED) ? SPEED_W'(speed_acc) : '0;
      want.target_x     = COORD_W'(x);
      want.target_y     = COORD_W'(y);
      awaited.push_back(want);
      restart_line();
    endfunction

    function void check_result(line_result_t got);
      line_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] unexpected result: cmd %0d speed %0d x %0d y %0d", $realtime,
                   got.command, got.speed_tenths, $signed(got.target_x),
                   $signed(got.target_y));
        return;
      end
      want = awaited.pop_front();
      results_checked++;
      if (got.command !== want.command || got.speed_tenths !== want.speed_tenths ||
          got.target_x !== want.target_x || got.target_y !== want.target_y) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result mismatch: expected cmd %0d speed %0d x %0d y %0d, got cmd %0d speed %0d x %0d y %0d",
                   $realtime, want.command, want.speed_tenths, $signed(want.target_x),
                   $signed(want.target_y), got.command, got.speed_tenths,
                   $signed(got.target_x), $signed(got.target_y));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  dclp_byte_if   byte_ch ();
  dclp_result_if result_ch ();

  drive_command_line_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  line_result_board board = new();

  logic [BYTE_W-1:0] line_q[$];
  int unsigned       gap_pct   = 0;
  int unsigned       stall_pct = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       lines_sent = 0;

  always #6 clk = ~clk;

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready)
        board.parse_byte(byte_ch.text_byte, byte_ch.line_end);
      if (result_ch.valid && result_ch.ready)
        board.check_result('{result_ch.command, result_ch.speed_tenths,
                             result_ch.target_x, result_ch.target_y});
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [BYTE_W-1:0] c, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      byte_ch.valid <= 1'b0;
      @(negedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.text_byte <= c;
    byte_ch.line_end  <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    line_q.delete();
    foreach (s[i]) line_q.push_back(s[i]);
    send_line();
  endtask

  // A signed decimal with occasional stray bytes, long runs of digits and
  // over-long fractions.
  function automatic void append_number();
    int unsigned int_digits;
    int unsigned frac_digits;
    int_digits = ($urandom_range(7) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 0);
    if ($urandom_range(2) == 0) line_q.push_back(CH_MINUS);
    for (int i = 0; i < int_digits; i++) begin
      if ($urandom_range(19) == 0) line_q.push_back(BYTE_W'($urandom_range(255)));
      line_q.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
    end
    if ($urandom_range(1) == 0) begin
      line_q.push_back(CH_DOT);
      frac_digits = $urandom_range(7);
      for (int i = 0; i < frac_digits; i++) begin
        if ($urandom_range(24) == 0)
          line_q.push_back(($urandom_range(1) == 0) ? CH_DOT : CH_MINUS);
        line_q.push_back(CH_ZERO + BYTE_W'($urandom_range(9)));
      end
    end
    if ($urandom_range(19) == 0) line_q.push_back(CH_MINUS);
  endfunction

  // Mostly well-formed lines weighted towards the speed and point commands,
  // with some lines of pure noise.
  function automatic void build_random_line();
    int unsigned pick;
    int unsigned fields;
    line_q.delete();
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(10, 1)) line_q.push_back(BYTE_W'($urandom_range(255)));
      return;
    end
    pick = $urandom_range(9);
    if (pick == 0)
      line_q.push_back(BYTE_W'($urandom_range(255)));
    else if (pick <= 4)
      line_q.push_back(CH_EIGHT);
    else if (pick <= 6)
      line_q.push_back(CH_ZERO + BYTE_W'(CMD_SPEED));
    else
      line_q.push_back(CH_ZERO + BYTE_W'($urandom_range(6)));
    if ($urandom_range(7) == 0) line_q.push_back(BYTE_W'($urandom_range(255)));
    fields = ($urandom_range(9) < 7) ? 2 : $urandom_range(4);
    for (int f = 0; f < fields; f++) begin
      line_q.push_back(CH_COMMA);
      if ($urandom_range(9) != 0) append_number();
    end
  endfunction

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("No item moved on either channel for %0d cycles.", QUIET_LIMIT);
    $display("drive_command_line_parser regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_start;
    rst               = 1'b1;
    byte_ch.valid     = 1'b0;
    byte_ch.text_byte = '0;
    byte_ch.line_end  = 1'b0;
    result_ch.ready   = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      gap_pct   = GAP_PCT[p];
      stall_pct = STALL_PCT[p];
      if (p == 0) begin
        // Single-byte lines at both ends of the byte range.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Stray byte in the speed field, then a value past the speed ceiling.
        send_text("7,x70000");
        // Fraction longer than four digits and no y field.
        send_text("8,1.23456");
        // Extra bytes in the command field and a lone minus in x.
        send_text("3a,-");
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_random_line();
        send_line();
      end
    end
    byte_ch.valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d lines in %0d bytes over four handshake phases; checked %0d results.",
             lines_sent, bytes_sent, board.results_checked);
    $display("Lines with point commands: %0d, with speed commands: %0d, mismatches: %0d.",
             board.point_lines, board.speed_lines, board.mismatches);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("drive_command_line_parser regression: pass");
    end else begin
      $display("drive_command_line_parser regression: fail");
    end
    $finish;
  end

endmodule
